>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/gpwg_pkg.sv
// ----------------------------------------------------------------------------
// gpwg_pkg
// constants and codes for the gait phase wave generator
// ----------------------------------------------------------------------------
package gpwg_pkg;
	localparam int NUM_LEGS_DEF      = 4;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int OUT_LEGS          = 4;
	localparam int TIME_W            = 32;
	localparam int PERIOD_W          = 24;
	localparam int RATIO_W           = 16;
	localparam int OFFSET_W          = 17;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 24;

	localparam logic [1:0] MODE_WAVE   = 2'd0;
	localparam logic [1:0] MODE_SWING  = 2'd1;
	localparam logic [1:0] MODE_STANCE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF0   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF3   = 3'd5;
endpackage

>>> hw/rtl/gpwg_in_if.sv
// ----------------------------------------------------------------------------
// gpwg_in_if
// input channel: elapsed time and requested mode
// ----------------------------------------------------------------------------
interface gpwg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] elapsed_us;
	logic [1:0]  mode;
	modport source (output valid, elapsed_us, mode, input ready);
	modport sink (input valid, elapsed_us, mode, output ready);
endinterface

>>> hw/rtl/gpwg_out_if.sv
// ----------------------------------------------------------------------------
// gpwg_out_if
// output channel: contact mask, leg phases and mode in effect
// ----------------------------------------------------------------------------
interface gpwg_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  contact_mask;
	logic [15:0] phase_leg0;
	logic [15:0] phase_leg1;
	logic [15:0] phase_leg2;
	logic [15:0] phase_leg3;
	logic [1:0]  mode_in_effect;
	modport source (output valid, contact_mask, phase_leg0, phase_leg1, phase_leg2,
		phase_leg3, mode_in_effect, input ready);
	modport sink (input valid, contact_mask, phase_leg0, phase_leg1, phase_leg2,
		phase_leg3, mode_in_effect, output ready);
endinterface

>>> hw/rtl/gait_phase_wave_generator.sv
// wave mode runs two divisions per leg, leg by leg, on the shared bit-serial divider,
// then FIN and OUT; a switch away from a held wave mode repeats the divisions for it
// fixed modes skip the divider and go from accept straight to FIN; a fixed-to-fixed
// switch repeats FIN before OUT
// a finished result waits in the output register; ready returns the cycle after it is taken
// arst_n clears registers to their defaults, held mode all swing, phases one half
// ----------------------------------------------------------------------------
// gait_phase_wave_generator
// per leg stance contact and phase from elapsed time, with held mode switching
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module gait_phase_wave_generator #(
	parameter int NUM_LEGS      = gpwg_pkg::NUM_LEGS_DEF,
	parameter int FRACTION_BITS = gpwg_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gpwg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gpwg_pkg::CFG_DATA_W-1:0] cfg_data,
	gpwg_in_if.sink                     in_ch,
	gpwg_out_if.source                  out_ch
);
	localparam int F   = FRACTION_BITS;
	localparam int LW  = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
	localparam int PW  = gpwg_pkg::PERIOD_W;
	localparam int NW  = gpwg_pkg::TIME_W + F + 2;
	localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
	localparam logic [F-1:0] HALF = {1'b1, {(F-1){1'b0}}};

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_D1   = 3'd1;
	localparam logic [2:0] ST_W1   = 3'd2;
	localparam logic [2:0] ST_D2   = 3'd3;
	localparam logic [2:0] ST_W2   = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [PW-1:0]  period_q;
	logic [15:0]    ratio_q;
	logic [16:0]    offset_q [4];

	logic [1:0]     held_mode_q;
	logic [NUM_LEGS-1:0] held_con_q;
	logic [F-1:0]   held_ph_q [NUM_LEGS];
	logic [NUM_LEGS-1:0] pend_q;

	logic [2:0]     state_q;
	logic [LW-1:0]  leg_q;
	logic           pass_q;    // 0 requested mode, 1 held mode
	logic [31:0]    t_q;
	logic [1:0]     mode_q;
	logic [NUM_LEGS-1:0] con_q;
	logic [F-1:0]   ph_q [NUM_LEGS];
	logic [NUM_LEGS-1:0] hcon_q;
	logic [F-1:0]   hph_q [NUM_LEGS];
	logic [F:0]     n_q;

	logic           div_start;
	logic [NW-1:0]  div_num;
	logic [PW-1:0]  div_den;
	logic           div_done;
	logic [NW-1:0]  div_quo;

	gpwg_divider #(.NW(NW), .DW(PW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	// saturated operands
	logic [PW-1:0] p_eff;
	logic [F:0]    r_eff;
	logic [F:0]    o_eff;
	logic [1:0]    in_mode_n;
	logic [1:0]    cur_mode;
	logic [F:0]    ratio_ext;
	logic [16:0]   off_raw;
	logic          leg_in_range;

	assign p_eff = (period_q == '0) ? PW'(1) : period_q;
	always_comb begin
		ratio_ext = (F + 1)'(ratio_q);
		if (F < 16 && ratio_q > 16'(ONE - 1'b1)) ratio_ext = ONE - 1'b1;
		r_eff = (ratio_ext == '0) ? (F + 1)'(1) : ratio_ext;
		leg_in_range = (32'(leg_q) < 32'd4);
		off_raw = leg_in_range ? offset_q[leg_q[1:0]] : 17'd0;
		o_eff = ((F + 1 < 17) ? (off_raw > 17'(ONE)) : (32'(off_raw) > 32'(ONE)))
			? ONE : (F + 1)'(off_raw);
		in_mode_n = (in_ch.mode == 2'd3) ? gpwg_pkg::MODE_STANCE : in_ch.mode;
		cur_mode = pass_q ? held_mode_q : mode_q;
	end

	// first division: (t*2^F + P*2^F - P*o) mod P*2^F, then /P equals
	// ((t + P - P*o/2^F) ...) done exactly as num = t*2^F + P*(2^F - o), quotient
	// mod 2^F after dividing by P
	logic [NW-1:0] num1;
	logic [NW-1:0] prod_po;
	logic [F:0]    n_next;
	logic [F:0]    d2_den;
	logic [F:0]    d2_n;
	assign prod_po = NW'(p_eff) * NW'(ONE - o_eff);
	assign num1    = {2'b00, t_q, {F{1'b0}}} + prod_po;
	assign n_next  = {1'b0, div_quo[F-1:0]};
	assign d2_n    = (n_q < r_eff) ? n_q : n_q - r_eff;
	assign d2_den  = (n_q < r_eff) ? r_eff : ONE - r_eff;

	always_comb begin
		div_start = 1'b0;
		div_num   = num1;
		div_den   = p_eff;
		if (state_q == ST_D1) div_start = 1'b1;
		if (state_q == ST_D2) begin
			div_start = 1'b1;
			div_num   = NW'({d2_n, {F{1'b0}}});
			div_den   = PW'(d2_den);
		end
	end

	logic          last_leg;
	assign last_leg = (leg_q == LW'(NUM_LEGS - 1));

	// mode switch decision, combinational over legs
	logic          mode_change;
	logic [NUM_LEGS-1:0] hc_fix;
	logic [NUM_LEGS-1:0] pend_after;
	logic [NUM_LEGS-1:0] pend_new;
	logic [NUM_LEGS-1:0] con_out;
	logic [F-1:0]  ph_out [NUM_LEGS];
	always_comb begin
		mode_change = (mode_q != held_mode_q);
		hc_fix = hcon_q;
		if (mode_q == gpwg_pkg::MODE_STANCE && held_mode_q == gpwg_pkg::MODE_SWING)
			hc_fix = '1;
		else if (mode_q == gpwg_pkg::MODE_SWING && held_mode_q == gpwg_pkg::MODE_STANCE)
			hc_fix = '0;
		if (!mode_change) hc_fix = held_con_q;
		pend_after = (mode_change && pend_q == '0) ? '1 : pend_q;
		pend_new = pend_after;
		con_out = con_q;
		for (int i = 0; i < NUM_LEGS; i++) begin
			ph_out[i] = ph_q[i];
			if (pend_after != '0) begin
				if (con_q[i] == hc_fix[i]) begin
					pend_new[i] = 1'b0;
				end else begin
					con_out[i] = hc_fix[i];
					ph_out[i] = mode_change ? hph_q[i] : held_ph_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PW'(500000);
			ratio_q     <= 16'd32768;
			offset_q[0] <= 17'd0;
			offset_q[1] <= 17'd32768;
			offset_q[2] <= 17'd32768;
			offset_q[3] <= 17'd0;
			held_mode_q <= gpwg_pkg::MODE_SWING;
			held_con_q  <= '0;
			pend_q      <= '0;
			for (int i = 0; i < NUM_LEGS; i++) held_ph_q[i] <= HALF;
			state_q     <= ST_IDLE;
			leg_q       <= '0;
			pass_q      <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == gpwg_pkg::REG_PERIOD) period_q <= cfg_data;
				else if (cfg_index == gpwg_pkg::REG_RATIO) ratio_q <= cfg_data[15:0];
				else if (cfg_index >= gpwg_pkg::REG_OFF0 && cfg_index <= gpwg_pkg::REG_OFF3)
					offset_q[2'(cfg_index - gpwg_pkg::REG_OFF0)] <= cfg_data[16:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						leg_q  <= '0;
						pass_q <= 1'b0;
						state_q <= ST_FIN;
						if (in_mode_n == gpwg_pkg::MODE_WAVE) state_q <= ST_D1;
					end
				end
				ST_D1: state_q <= ST_W1;
				ST_W1: if (div_done) state_q <= ST_D2;
				ST_D2: state_q <= ST_W2;
				ST_W2: begin
					if (div_done) begin
						if (last_leg) begin
							leg_q <= '0;
							state_q <= ST_FIN;
						end else begin
							leg_q <= leg_q + 1'b1;
							state_q <= ST_D1;
						end
					end
				end
				ST_FIN: begin
					if (!pass_q && mode_q != held_mode_q) begin
						pass_q <= 1'b1;
						state_q <= (held_mode_q == gpwg_pkg::MODE_WAVE) ? ST_D1 : ST_FIN;
						if (held_mode_q != gpwg_pkg::MODE_WAVE) pass_q <= 1'b1;
					end else begin
						if (mode_change) begin
							held_ph_q <= hph_q;
						end
						held_con_q <= mode_change ? hc_fix : held_con_q;
						pend_q <= pend_new;
						if (pend_after != '0 && pend_new == '0) held_mode_q <= mode_q;
						state_q <= ST_OUT;
						out_ch.valid <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			t_q    <= in_ch.elapsed_us;
			mode_q <= in_mode_n;
			for (int i = 0; i < NUM_LEGS; i++) begin
				con_q[i] <= (in_mode_n == gpwg_pkg::MODE_STANCE);
				ph_q[i]  <= HALF;
			end
		end
		if (state_q == ST_FIN && !pass_q && mode_q != held_mode_q
				&& held_mode_q != gpwg_pkg::MODE_WAVE) begin
			for (int i = 0; i < NUM_LEGS; i++) begin
				hcon_q[i] <= (held_mode_q == gpwg_pkg::MODE_STANCE);
				hph_q[i]  <= HALF;
			end
		end
		if (state_q == ST_W1 && div_done) n_q <= n_next;
		if (state_q == ST_W2 && div_done) begin
			if (cur_mode == gpwg_pkg::MODE_WAVE && !pass_q) begin
				con_q[leg_q] <= (n_q < r_eff);
				ph_q[leg_q]  <= div_quo[F-1:0];
			end else begin
				hcon_q[leg_q] <= (n_q < r_eff);
				hph_q[leg_q]  <= div_quo[F-1:0];
			end
		end
		if (state_q == ST_FIN && !(!pass_q && mode_q != held_mode_q)) begin
			out_ch.mode_in_effect <= (pend_after != '0 && pend_new == '0)
				? mode_q : held_mode_q;
			for (int i = 0; i < gpwg_pkg::OUT_LEGS; i++) begin
				if (i < NUM_LEGS) out_ch.contact_mask[i] <= con_out[i];
				else out_ch.contact_mask[i] <= 1'b0;
			end
			out_ch.phase_leg0 <= 16'(ph_out[0]);
			out_ch.phase_leg1 <= (NUM_LEGS > 1) ? 16'(ph_out[1 % NUM_LEGS]) : 16'd0;
			out_ch.phase_leg2 <= (NUM_LEGS > 2) ? 16'(ph_out[2 % NUM_LEGS]) : 16'd0;
			out_ch.phase_leg3 <= (NUM_LEGS > 3) ? 16'(ph_out[3 % NUM_LEGS]) : 16'd0;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	`ASSERT_IMPL(a_busy_not_ready, clk, arst_n, (state_q != ST_IDLE) |-> !in_ch.ready)
	`ASSERT_IMPL(a_valid_in_out, clk, arst_n, out_ch.valid |-> (state_q == ST_OUT))
	`ASSERT_NEVER(a_held_mode_three, clk, arst_n, held_mode_q == 2'd3)
	`ASSERT_IMPL(a_accept_starts, clk, arst_n, (in_ch.valid && in_ch.ready) |=> (state_q != ST_IDLE))
endmodule

>>> hw/rtl/gpwg_divider.sv
// ----------------------------------------------------------------------------
// gpwg_divider
// shared restoring divider, one quotient bit per cycle while busy
// ----------------------------------------------------------------------------
module gpwg_divider #(
	parameter int NW = 64,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
endmodule
